@@ rtl/omrs_pkg.sv @@
// shared types, codes and allow tables of the opentherm master request scheduler
package omrs_pkg;

   // command codes of an input word
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_FRAME     = 3'd1;
   localparam logic [2:0] CMD_REQ_READ  = 3'd2;
   localparam logic [2:0] CMD_REQ_WRITE = 3'd3;
   localparam logic [2:0] CMD_STORE     = 3'd4;
   localparam logic [2:0] CMD_FETCH     = 3'd5;

   // received message types
   localparam logic [2:0] FT_READ_ACK  = 3'd4;
   localparam logic [2:0] FT_WRITE_ACK = 3'd5;
   localparam logic [2:0] FT_UNKNOWN   = 3'd7;

   // sent message types
   localparam logic [1:0] ST_READ    = 2'd0;
   localparam logic [1:0] ST_WRITE   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_SEND      = 3'd0;
   localparam logic [2:0] KIND_READ_RSP  = 3'd1;
   localparam logic [2:0] KIND_WRITE_RSP = 3'd2;
   localparam logic [2:0] KIND_REQ_ANS   = 3'd3;
   localparam logic [2:0] KIND_FETCH     = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;
   localparam logic [1:0] STAT_REJECT  = 2'd1;

   // register indexes (paddr[3:2])
   localparam logic [1:0] CSR_IDX_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_IDX_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_IDX_GAP     = 2'd2;

   // reset values of the registers
   localparam logic [7:0] TIMEOUT_RESET = 8'd10;
   localparam logic [7:0] GAP_RESET     = 8'd2;

   // reply mark value that means a reply is awaited
   localparam logic [7:0] MARK_AWAIT = 8'hFF;

   // pending bits examined per scan cycle
   localparam int SCAN_GROUP_W = 32;
   localparam int SCAN_POS_W   = 5;

   // allow tables, one bit per data-id, byte k holds ids 8k..8k+7
   localparam logic [7:0] READ_OK_TAB [16] = '{
      8'h69, 8'hBE, 8'h7E, 8'hFE, 8'h5F, 8'h00, 8'h03, 8'h03,
      8'h40, 8'hFF, 8'hFF, 8'h0F, 8'hF8, 8'hFF, 8'hFF, 8'hAF
   };
   localparam logic [7:0] WRITE_OK_TAB [16] = '{
      8'h96, 8'h49, 8'hF1, 8'h09, 8'h60, 8'h00, 8'h00, 8'h03,
      8'h80, 8'hC0, 8'h80, 8'h02, 8'h0C, 8'h64, 8'hF7, 8'h5F
   };

   typedef struct packed {
      logic       enable;
      logic [7:0] timeout_ticks;
      logic [7:0] reply_gap_ticks;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic finish;
      logic send;
      logic fetch_out;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] command;
      logic       need_scan;
      logic       scan_stop;
      logic       frame_sel;
   } dp_status_type;

   function automatic logic read_allowed(input logic [7:0] id);
      logic [7:0] row;
      row = READ_OK_TAB[id[6:3]];
      return !id[7] && row[id[2:0]];
   endfunction

   function automatic logic write_allowed(input logic [7:0] id);
      logic [7:0] row;
      row = WRITE_OK_TAB[id[6:3]];
      return !id[7] && row[id[2:0]];
   endfunction

endpackage

@@ rtl/omrs_ram.sv @@
// generic single-port-write, registered-read ram
module omrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/omrs_ctrl.sv @@
// controller state machine of the request scheduler
module omrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  omrs_pkg::dp_status_type status,
   output omrs_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH,
      S_SEND,
      S_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (status.command == omrs_pkg::CMD_TICK && status.need_scan) begin
               state_in = S_SCAN;
            end else if (status.command == omrs_pkg::CMD_FETCH) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (status.scan_stop) state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = status.frame_sel ? S_SEND : S_IDLE;
         end
         S_SEND:  state_in = S_IDLE;
         S_FETCH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && start;
      cmd.exec      = (state_ff == S_EXEC);
      cmd.scan      = (state_ff == S_SCAN);
      cmd.finish    = (state_ff == S_FINISH);
      cmd.send      = (state_ff == S_SEND);
      cmd.fetch_out = (state_ff == S_FETCH);
   end

   assign busy = busy_ff;

endmodule

@@ rtl/omrs_dpath.sv @@
// datapath of the request scheduler: counters, pending bits, value table, result word
module omrs_dpath #(
   parameter int OBJECT_COUNT = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  omrs_pkg::cfg_type       cfg,
   input  omrs_pkg::ctrl_cmd_type  cmd,
   output omrs_pkg::dp_status_type status,
   input  logic [2:0]              req_command,
   input  logic [2:0]              req_frame_type,
   input  logic [7:0]              req_data_id,
   input  logic [15:0]             req_data_value,
   output logic                    rsp_strobe,
   output logic [2:0]              rsp_kind,
   output logic [2:0]              rsp_send_type,
   output logic [7:0]              rsp_result_id,
   output logic [15:0]             rsp_result_value,
   output logic [1:0]              rsp_status
);

   localparam int GW     = omrs_pkg::SCAN_GROUP_W;
   localparam int PW     = omrs_pkg::SCAN_POS_W;
   localparam int NGROUP = (OBJECT_COUNT + GW - 1) / GW;
   localparam int PAD_W  = NGROUP * GW;
   localparam int GCW    = NGROUP > 1 ? $clog2(NGROUP) : 1;
   localparam int AW     = OBJECT_COUNT > 1 ? $clog2(OBJECT_COUNT) : 1;

   // lowest set bit of a scan group
   function automatic logic [PW-1:0] lowest_bit(input logic [GW-1:0] v);
      logic [PW-1:0] pos;
      pos = '0;
      for (int i = GW - 1; i >= 0; i--) begin
         if (v[i]) pos = PW'(i);
      end
      return pos;
   endfunction

   // latched input word
   logic [2:0]  cmd_ff, cmd_in;
   logic [2:0]  ftype_ff, ftype_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] value_ff, value_in;

   // scheduler state
   logic [7:0]              tick_ff, tick_in;
   logic [7:0]              mark_ff, mark_in;
   logic [1:0]              last_ff, last_in;
   logic [15:0]             inv_cnt_ff, inv_cnt_in;
   logic [OBJECT_COUNT-1:0] rpend_ff, rpend_in;
   logic [OBJECT_COUNT-1:0] wpend_ff, wpend_in;
   logic [OBJECT_COUNT-1:0] valid_ff, valid_in;

   // scan state
   logic           timeout_ff, timeout_in;
   logic [GCW-1:0] group_ff, group_in;
   logic           rfound_ff, rfound_in;
   logic           wfound_ff, wfound_in;
   logic [7:0]     rid_ff, rid_in;
   logic [7:0]     wid_ff, wid_in;
   logic [7:0]     sel_id_ff, sel_id_in;
   logic [1:0]     sel_type_ff, sel_type_in;
   logic           rd_valid_ff, rd_valid_in;

   // result word
   logic        out_strobe_ff, out_strobe_in;
   logic [2:0]  out_kind_ff, out_kind_in;
   logic [2:0]  out_stype_ff, out_stype_in;
   logic [7:0]  out_id_ff, out_id_in;
   logic [15:0] out_value_ff, out_value_in;
   logic [1:0]  out_status_ff, out_status_in;

   // combinational helpers
   logic              in_range;
   logic [7:0]        tick_next;
   logic signed [9:0] gap_diff;
   logic              gap_ok;
   logic              timeout_hit;
   logic [PAD_W-1:0]  rpad, wpad;
   logic [GW-1:0]     rgroup, wgroup;
   logic [7:0]        rhit_id, whit_id;
   logic [7:0]        pick_id;
   logic              ram_we;
   logic [AW-1:0]     ram_raddr;
   logic [15:0]       ram_rdata;
   logic [15:0]       rd_value;

   assign in_range    = ({24'd0, id_ff} < 32'(OBJECT_COUNT));
   assign tick_next   = tick_ff + 8'd1;
   assign gap_diff    = $signed({2'b00, tick_next}) - $signed({2'b00, mark_ff});
   assign gap_ok      = (mark_ff != omrs_pkg::MARK_AWAIT)
                        && (gap_diff > $signed({2'b00, cfg.reply_gap_ticks}));
   assign timeout_hit = (tick_next >= cfg.timeout_ticks);

   // current scan group of both pending sets
   assign rpad    = PAD_W'(rpend_ff);
   assign wpad    = PAD_W'(wpend_ff);
   assign rgroup  = rpad[group_ff*GW +: GW];
   assign wgroup  = wpad[group_ff*GW +: GW];
   assign rhit_id = 8'({group_ff, lowest_bit(rgroup)});
   assign whit_id = 8'({group_ff, lowest_bit(wgroup)});
   assign pick_id = rfound_ff ? rid_ff : wid_ff;

   // value table port
   assign ram_we = cmd.exec && in_range
                   && (cmd_ff == omrs_pkg::CMD_STORE
                       || (cmd_ff == omrs_pkg::CMD_FRAME && last_ff == omrs_pkg::ST_READ
                           && ftype_ff == omrs_pkg::FT_READ_ACK));
   assign ram_raddr = cmd.finish ? pick_id[AW-1:0] : id_ff[AW-1:0];
   assign rd_value  = rd_valid_ff ? ram_rdata : 16'd0;

   omrs_ram #(
      .WIDTH(16),
      .DEPTH(OBJECT_COUNT)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(id_ff[AW-1:0]),
      .wdata(value_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // next values
   always_comb begin
      cmd_in        = cmd_ff;
      ftype_in      = ftype_ff;
      id_in         = id_ff;
      value_in      = value_ff;
      tick_in       = tick_ff;
      mark_in       = mark_ff;
      last_in       = last_ff;
      inv_cnt_in    = inv_cnt_ff;
      rpend_in      = rpend_ff;
      wpend_in      = wpend_ff;
      valid_in      = valid_ff;
      timeout_in    = timeout_ff;
      group_in      = group_ff;
      rfound_in     = rfound_ff;
      wfound_in     = wfound_ff;
      rid_in        = rid_ff;
      wid_in        = wid_ff;
      sel_id_in     = sel_id_ff;
      sel_type_in   = sel_type_ff;
      rd_valid_in   = rd_valid_ff;
      out_strobe_in = 1'b0;
      out_kind_in   = out_kind_ff;
      out_stype_in  = out_stype_ff;
      out_id_in     = out_id_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      // accept a word
      if (cmd.load) begin
         cmd_in   = req_command;
         ftype_in = req_frame_type;
         id_in    = req_data_id;
         value_in = req_data_value;
      end

      // decode and run the word
      if (cmd.exec) begin
         rd_valid_in = valid_ff[ram_raddr];
         case (cmd_ff)
            omrs_pkg::CMD_TICK: begin
               group_in  = '0;
               rfound_in = 1'b0;
               wfound_in = 1'b0;
               if (!cfg.enable) begin
                  tick_in = 8'd0;
                  mark_in = 8'd0;
               end else begin
                  tick_in    = tick_next;
                  timeout_in = timeout_hit;
               end
            end
            omrs_pkg::CMD_FRAME: begin
               mark_in = tick_ff;
               if (last_ff == omrs_pkg::ST_READ || last_ff == omrs_pkg::ST_WRITE) begin
                  out_strobe_in = 1'b1;
                  out_stype_in  = 3'd0;
                  out_id_in     = id_ff;
                  out_value_in  = 16'd0;
                  if (last_ff == omrs_pkg::ST_READ) begin
                     out_kind_in = omrs_pkg::KIND_READ_RSP;
                     if (ftype_ff == omrs_pkg::FT_READ_ACK) begin
                        out_status_in = omrs_pkg::STAT_OK;
                     end else if (ftype_ff == omrs_pkg::FT_UNKNOWN) begin
                        out_status_in = omrs_pkg::STAT_UNKNOWN;
                     end else begin
                        out_status_in = omrs_pkg::STAT_INVALID;
                     end
                  end else begin
                     out_kind_in = omrs_pkg::KIND_WRITE_RSP;
                     if (ftype_ff == omrs_pkg::FT_WRITE_ACK) begin
                        out_status_in = omrs_pkg::STAT_OK;
                     end else if (ftype_ff == omrs_pkg::FT_UNKNOWN) begin
                        out_status_in = omrs_pkg::STAT_UNKNOWN;
                     end else begin
                        out_status_in = omrs_pkg::STAT_INVALID;
                     end
                  end
               end
            end
            omrs_pkg::CMD_REQ_READ, omrs_pkg::CMD_REQ_WRITE: begin
               out_strobe_in = 1'b1;
               out_kind_in   = omrs_pkg::KIND_REQ_ANS;
               out_stype_in  = 3'd0;
               out_id_in     = id_ff;
               out_value_in  = 16'd0;
               out_status_in = omrs_pkg::STAT_REJECT;
               if (cmd_ff == omrs_pkg::CMD_REQ_READ) begin
                  if (in_range && omrs_pkg::read_allowed(id_ff)) begin
                     out_status_in = omrs_pkg::STAT_OK;
                     for (int i = 0; i < OBJECT_COUNT; i++) begin
                        if (id_ff == 8'(i)) rpend_in[i] = 1'b1;
                     end
                  end
               end else begin
                  if (in_range && omrs_pkg::write_allowed(id_ff)) begin
                     out_status_in = omrs_pkg::STAT_OK;
                     for (int i = 0; i < OBJECT_COUNT; i++) begin
                        if (id_ff == 8'(i)) wpend_in[i] = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         // table entry written now reads back as stored
         if (ram_we) begin
            for (int i = 0; i < OBJECT_COUNT; i++) begin
               if (id_ff == 8'(i)) valid_in[i] = 1'b1;
            end
         end
      end

      // one scan group per cycle, lowest read first, first write kept
      if (cmd.scan) begin
         group_in = group_ff + GCW'(1);
         if (|rgroup) begin
            rfound_in = 1'b1;
            rid_in    = rhit_id;
         end
         if ((|wgroup) && !wfound_ff) begin
            wfound_in = 1'b1;
            wid_in    = whit_id;
         end
      end

      // pick the frame to send
      if (cmd.finish) begin
         rd_valid_in = valid_ff[ram_raddr];
         if (rfound_ff || wfound_ff) begin
            sel_id_in   = pick_id;
            sel_type_in = rfound_ff ? omrs_pkg::ST_READ : omrs_pkg::ST_WRITE;
            last_in     = rfound_ff ? omrs_pkg::ST_READ : omrs_pkg::ST_WRITE;
            tick_in     = 8'd0;
            mark_in     = omrs_pkg::MARK_AWAIT;
            for (int i = 0; i < OBJECT_COUNT; i++) begin
               if (rfound_ff && rid_ff == 8'(i)) rpend_in[i] = 1'b0;
               if (!rfound_ff && wid_ff == 8'(i)) wpend_in[i] = 1'b0;
            end
         end else if (timeout_ff) begin
            last_in       = omrs_pkg::ST_INVALID;
            tick_in       = 8'd0;
            mark_in       = omrs_pkg::MARK_AWAIT;
            inv_cnt_in    = inv_cnt_ff + 16'd1;
            out_strobe_in = 1'b1;
            out_kind_in   = omrs_pkg::KIND_SEND;
            out_stype_in  = {1'b0, omrs_pkg::ST_INVALID};
            out_id_in     = 8'd0;
            out_value_in  = inv_cnt_ff;
            out_status_in = omrs_pkg::STAT_OK;
         end
      end

      // read or write frame with its table value
      if (cmd.send) begin
         out_strobe_in = 1'b1;
         out_kind_in   = omrs_pkg::KIND_SEND;
         out_stype_in  = {1'b0, sel_type_ff};
         out_id_in     = sel_id_ff;
         out_value_in  = rd_value;
         out_status_in = omrs_pkg::STAT_OK;
      end

      // fetched value
      if (cmd.fetch_out) begin
         out_strobe_in = 1'b1;
         out_kind_in   = omrs_pkg::KIND_FETCH;
         out_stype_in  = 3'd0;
         out_id_in     = id_ff;
         out_value_in  = in_range ? rd_value : 16'd0;
         out_status_in = in_range ? omrs_pkg::STAT_OK : omrs_pkg::STAT_REJECT;
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= 8'd0;
         mark_ff       <= 8'd0;
         last_ff       <= omrs_pkg::ST_READ;
         inv_cnt_ff    <= 16'd0;
         rpend_ff      <= '0;
         wpend_ff      <= '0;
         valid_ff      <= '0;
         out_strobe_ff <= 1'b0;
      end else begin
         tick_ff       <= tick_in;
         mark_ff       <= mark_in;
         last_ff       <= last_in;
         inv_cnt_ff    <= inv_cnt_in;
         rpend_ff      <= rpend_in;
         wpend_ff      <= wpend_in;
         valid_ff      <= valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ftype_ff      <= ftype_in;
      id_ff         <= id_in;
      value_ff      <= value_in;
      timeout_ff    <= timeout_in;
      group_ff      <= group_in;
      rfound_ff     <= rfound_in;
      wfound_ff     <= wfound_in;
      rid_ff        <= rid_in;
      wid_ff        <= wid_in;
      sel_id_ff     <= sel_id_in;
      sel_type_ff   <= sel_type_in;
      rd_valid_ff   <= rd_valid_in;
      out_kind_ff   <= out_kind_in;
      out_stype_ff  <= out_stype_in;
      out_id_ff     <= out_id_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   // status to the controller
   always_comb begin
      status           = '0;
      status.command   = cmd_ff;
      status.need_scan = cfg.enable && (timeout_hit || gap_ok);
      status.scan_stop = (|rgroup) || (group_ff == GCW'(NGROUP - 1));
      status.frame_sel = rfound_ff || wfound_ff;
   end

   assign rsp_strobe       = out_strobe_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_send_type    = out_stype_ff;
   assign rsp_result_id    = out_id_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_status       = out_status_ff;

endmodule

@@ rtl/opentherm_master_request_scheduler.sv @@
// top level of the opentherm master request scheduler
//
//   channel   ports                      handshake
//   request   start, busy, req_*         word taken when start && !busy
//   result    rsp_strobe, rsp_*          one-cycle strobe, always taken
//   config    psel, penable, pwrite ...  apb write in access cycle, pready tied high
//
// a request, store or frame word runs in the exec state, a fetch in the exec and fetch states
// a tick that may send runs the exec, scan, finish and send states; the
// pending-bit scan looks at 32 read and 32 write bits a cycle
// reset is synchronous; the value table needs no clearing pass, per-entry
// valid bits make unwritten entries read as zero
// the receiver cannot stall: each result is on rsp_* for exactly one cycle
module opentherm_master_request_scheduler #(
   parameter int OBJECT_COUNT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_frame_type,
   input  logic [7:0]  req_data_id,
   input  logic [15:0] req_data_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_send_type,
   output logic [7:0]  rsp_result_id,
   output logic [15:0] rsp_result_value,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   omrs_pkg::cfg_type       cfg;
   omrs_pkg::ctrl_cmd_type  cmd;
   omrs_pkg::dp_status_type status;

   logic       enable_ff, enable_in;
   logic [7:0] timeout_ff, timeout_in;
   logic [7:0] gap_ff, gap_in;
   logic       csr_write;

   // register writes
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      enable_in  = enable_ff;
      timeout_in = timeout_ff;
      gap_in     = gap_ff;
      if (csr_write) begin
         case (paddr[3:2])
            omrs_pkg::CSR_IDX_ENABLE:  enable_in  = pwdata[0];
            omrs_pkg::CSR_IDX_TIMEOUT: timeout_in = pwdata[7:0];
            omrs_pkg::CSR_IDX_GAP:     gap_in     = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         timeout_ff <= omrs_pkg::TIMEOUT_RESET;
         gap_ff     <= omrs_pkg::GAP_RESET;
      end else begin
         enable_ff  <= enable_in;
         timeout_ff <= timeout_in;
         gap_ff     <= gap_in;
      end
   end

   // register reads
   always_comb begin
      case (paddr[3:2])
         omrs_pkg::CSR_IDX_ENABLE:  prdata = {31'd0, enable_ff};
         omrs_pkg::CSR_IDX_TIMEOUT: prdata = {24'd0, timeout_ff};
         omrs_pkg::CSR_IDX_GAP:     prdata = {24'd0, gap_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;

   assign cfg.enable          = enable_ff;
   assign cfg.timeout_ticks   = timeout_ff;
   assign cfg.reply_gap_ticks = gap_ff;

   omrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   omrs_dpath #(
      .OBJECT_COUNT(OBJECT_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_command),
      .req_frame_type  (req_frame_type),
      .req_data_id     (req_data_id),
      .req_data_value  (req_data_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_send_type   (rsp_send_type),
      .rsp_result_id   (rsp_result_id),
      .rsp_result_value(rsp_result_value),
      .rsp_status      (rsp_status)
   );

endmodule

@@ test/tb_opentherm_master_request_scheduler.sv @@
// self-checking testbench for the opentherm master request scheduler
`timescale 1ns / 1ps

// allow masks, bit n set when data-id n may be requested
localparam logic [127:0] READ_ALLOW = {
   8'hAF, 8'hFF, 8'hFF, 8'hF8, 8'h0F, 8'hFF, 8'hFF, 8'h40,
   8'h03, 8'h03, 8'h00, 8'h5F, 8'hFE, 8'h7E, 8'hBE, 8'h69
};
localparam logic [127:0] WRITE_ALLOW = {
   8'h5F, 8'hF7, 8'h64, 8'h0C, 8'h02, 8'h80, 8'hC0, 8'h80,
   8'h03, 8'h00, 8'h00, 8'h60, 8'h09, 8'hF1, 8'h49, 8'h96
};

localparam int          OBJECTS         = 128;
localparam logic [7:0]  DEFAULT_TIMEOUT = 8'd10;
localparam logic [7:0]  DEFAULT_GAP     = 8'd2;
localparam logic [7:0]  AWAIT_REPLY     = 8'hFF;
localparam logic [2:0]  CMD_SPARE_A     = 3'd6;
localparam logic [2:0]  CMD_SPARE_B     = 3'd7;
localparam logic [2:0]  FT_DATA_INVALID = 3'd6;

typedef struct packed {
   logic [2:0]  kind;
   logic [2:0]  send_type;
   logic [7:0]  id;
   logic [15:0] value;
   logic [1:0]  status;
} sched_result_type;

// predicts the scheduler and checks its result words in order
class sched_scoreboard_type;
   logic             enable;
   logic [7:0]       timeout_ticks;
   logic [7:0]       reply_gap_ticks;
   logic [7:0]       tick_count;
   logic [7:0]       reply_mark;
   bit               pending [2][OBJECTS];   // first index is the sent type, read or write
   logic [15:0]      values [OBJECTS];
   logic [1:0]       last_type;
   logic [15:0]      inv_frame_count;
   sched_result_type awaited_words [$];
   int               words_noted;
   int               results_checked;
   int               frames_sent;
   int               mismatches;

   function new();
      enable          = 1'b0;
      timeout_ticks   = DEFAULT_TIMEOUT;
      reply_gap_ticks = DEFAULT_GAP;
      tick_count      = '0;
      reply_mark      = '0;
      last_type       = omrs_pkg::ST_READ;
      inv_frame_count = '0;
      foreach (values[i]) values[i] = '0;
      foreach (pending[s, i]) pending[s][i] = 1'b0;
      words_noted     = 0;
      results_checked = 0;
      frames_sent     = 0;
      mismatches      = 0;
   endfunction

   function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
         omrs_pkg::CSR_IDX_ENABLE:  enable = data[0];
         omrs_pkg::CSR_IDX_TIMEOUT: timeout_ticks = data[7:0];
         omrs_pkg::CSR_IDX_GAP:     reply_gap_ticks = data[7:0];
         default: ;
      endcase
   endfunction

   function logic [31:0] register_value(logic [1:0] idx);
      case (idx)
         omrs_pkg::CSR_IDX_ENABLE:  return {31'b0, enable};
         omrs_pkg::CSR_IDX_TIMEOUT: return {24'b0, timeout_ticks};
         default:                   return {24'b0, reply_gap_ticks};
      endcase
   endfunction

   function sched_result_type answer_word(logic [2:0] kind, logic [7:0] id,
                                          logic [15:0] data, logic [1:0] status);
      sched_result_type w;
      w.kind      = kind;
      w.send_type = '0;
      w.id        = id;
      w.value     = data;
      w.status    = status;
      return w;
   endfunction

   // a sent frame restarts the tick count and waits for a reply
   function sched_result_type frame_word(logic [1:0] stype, logic [7:0] id,
                                         logic [15:0] data);
      sched_result_type w;
      tick_count  = '0;
      reply_mark  = AWAIT_REPLY;
      last_type   = stype;
      w.kind      = omrs_pkg::KIND_SEND;
      w.send_type = {1'b0, stype};
      w.id        = id;
      w.value     = data;
      w.status    = omrs_pkg::STAT_OK;
      return w;
   endfunction

   // lowest pending id of one type goes out
   function bit send_lowest(logic [1:0] stype, output sched_result_type w);
      for (int i = 0; i < OBJECTS; i++) begin
         if (pending[stype][i]) begin
            pending[stype][i] = 1'b0;
            w = frame_word(stype, 8'(i), values[i]);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function void note_word(logic [2:0] cmd, logic [2:0] ft, logic [7:0] id, logic [15:0] data);
      sched_result_type w;
      bit               produced;
      logic [1:0]       st;
      logic [127:0]     allow;
      produced = 1'b0;
      words_noted++;
      case (cmd)
         omrs_pkg::CMD_TICK: begin
            if (!enable) begin
               tick_count = '0;
               reply_mark = '0;
            end else begin
               tick_count++;
               if (tick_count >= timeout_ticks) begin
                  produced = 1'b1;
                  if (!send_lowest(omrs_pkg::ST_READ, w)
                      && !send_lowest(omrs_pkg::ST_WRITE, w)) begin
                     w = frame_word(omrs_pkg::ST_INVALID, '0, inv_frame_count);
                     inv_frame_count++;
                  end
               end else if (reply_mark != AWAIT_REPLY &&
                            (int'(tick_count) - int'(reply_mark)) > int'(reply_gap_ticks)) begin
                  produced = send_lowest(omrs_pkg::ST_READ, w)
                             || send_lowest(omrs_pkg::ST_WRITE, w);
               end
            end
         end
         omrs_pkg::CMD_FRAME: begin
            reply_mark = tick_count;
            st = (ft == omrs_pkg::FT_UNKNOWN) ? omrs_pkg::STAT_UNKNOWN : omrs_pkg::STAT_INVALID;
            if (last_type == omrs_pkg::ST_READ) begin
               if (ft == omrs_pkg::FT_READ_ACK) begin
                  st = omrs_pkg::STAT_OK;
                  if (id < OBJECTS) values[id[6:0]] = data;
               end
               w = answer_word(omrs_pkg::KIND_READ_RSP, id, '0, st);
               produced = 1'b1;
            end else if (last_type == omrs_pkg::ST_WRITE) begin
               if (ft == omrs_pkg::FT_WRITE_ACK) st = omrs_pkg::STAT_OK;
               w = answer_word(omrs_pkg::KIND_WRITE_RSP, id, '0, st);
               produced = 1'b1;
            end
         end
         omrs_pkg::CMD_REQ_READ, omrs_pkg::CMD_REQ_WRITE: begin
            allow = (cmd == omrs_pkg::CMD_REQ_READ) ? READ_ALLOW : WRITE_ALLOW;
            if (id < OBJECTS && allow[id[6:0]]) begin
               if (cmd == omrs_pkg::CMD_REQ_READ) pending[omrs_pkg::ST_READ][id[6:0]] = 1'b1;
               else pending[omrs_pkg::ST_WRITE][id[6:0]] = 1'b1;
               st = omrs_pkg::STAT_OK;
            end else begin
               st = omrs_pkg::STAT_REJECT;
            end
            w = answer_word(omrs_pkg::KIND_REQ_ANS, id, '0, st);
            produced = 1'b1;
         end
         omrs_pkg::CMD_STORE: begin
            if (id < OBJECTS) values[id[6:0]] = data;
         end
         omrs_pkg::CMD_FETCH: begin
            if (id < OBJECTS)
               w = answer_word(omrs_pkg::KIND_FETCH, id, values[id[6:0]], omrs_pkg::STAT_OK);
            else
               w = answer_word(omrs_pkg::KIND_FETCH, id, '0, omrs_pkg::STAT_REJECT);
            produced = 1'b1;
         end
         default: ;
      endcase
      if (produced) awaited_words.push_back(w);
   endfunction

   task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s is 0x%0h, predicted 0x%0h",
                                   results_checked, name, got, want));
   endtask

   task check_word(sched_result_type got);
      sched_result_type want;
      results_checked++;
      if (got.kind == omrs_pkg::KIND_SEND) frames_sent++;
      if (awaited_words.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d id %0d value 0x%0h",
                                   got.kind, got.id, got.value));
         return;
      end
      want = awaited_words.pop_front();
      compare_field("kind", 16'(got.kind), 16'(want.kind));
      compare_field("send_type", 16'(got.send_type), 16'(want.send_type));
      compare_field("result_id", 16'(got.id), 16'(want.id));
      compare_field("result_value", got.value, want.value);
      compare_field("status", 16'(got.status), 16'(want.status));
   endtask
endclass

module tb_opentherm_master_request_scheduler;

   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 90;

   logic        clock;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic        busy;
   logic [2:0]  req_command      = '0;
   logic [2:0]  req_frame_type   = '0;
   logic [7:0]  req_data_id      = '0;
   logic [15:0] req_data_value   = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_send_type;
   logic [7:0]  rsp_result_id;
   logic [15:0] rsp_result_value;
   logic [1:0]  rsp_status;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [3:0]  paddr            = '0;
   logic [31:0] pwdata           = '0;
   logic [31:0] prdata;
   logic        pready;

   sched_scoreboard_type sched = new();
   int                   settings_applied = 0;
   int                   idle_cycles = 0;

   opentherm_master_request_scheduler uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // note accepted words and check result words at each edge
   always @(posedge clock) begin
      sched_result_type seen;
      if (!reset) begin
         if (rsp_strobe) begin
            seen.kind      = rsp_kind;
            seen.send_type = rsp_send_type;
            seen.id        = rsp_result_id;
            seen.value     = rsp_result_value;
            seen.status    = rsp_status;
            sched.check_word(seen);
         end
         if (start && !busy)
            sched.note_word(req_command, req_frame_type, req_data_id, req_data_value);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one word and hold it until taken
   task automatic drive_word(logic [2:0] cmd, logic [2:0] ft, logic [7:0] id,
                             logic [15:0] data);
      start          <= 1'b1;
      req_command    <= cmd;
      req_frame_type <= ft;
      req_data_id    <= id;
      req_data_value <= data;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait for every predicted word, then let a word without result finish
   task automatic settle();
      start <= 1'b0;
      while (sched.awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sched.set_register(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic read_register(logic [1:0] idx);
      logic [31:0] mask;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      mask = (idx == omrs_pkg::CSR_IDX_ENABLE) ? 32'h1 : 32'hFF;
      if ((prdata & mask) !== sched.register_value(idx))
         sched.report_mismatch($sformatf("register %0d reads 0x%0h, predicted 0x%0h",
                                         idx, prdata & mask, sched.register_value(idx)));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_settings(logic en, logic [7:0] timeout, logic [7:0] gap);
      settle();
      write_register(omrs_pkg::CSR_IDX_ENABLE, {31'b0, en});
      write_register(omrs_pkg::CSR_IDX_TIMEOUT, {24'b0, timeout});
      write_register(omrs_pkg::CSR_IDX_GAP, {24'b0, gap});
      read_register(omrs_pkg::CSR_IDX_ENABLE);
      read_register(omrs_pkg::CSR_IDX_TIMEOUT);
      read_register(omrs_pkg::CSR_IDX_GAP);
      settings_applied++;
   endtask

   function automatic logic [7:0] pick_allowed(logic [127:0] allow);
      logic [7:0] id;
      id = 8'($urandom_range(0, OBJECTS - 1));
      for (int n = 0; n < 32 && !allow[id[6:0]]; n++)
         id = 8'($urandom_range(0, OBJECTS - 1));
      return id;
   endfunction

   // mostly well-formed traffic: acks that match the last frame, allowed ids
   task automatic random_word();
      logic [2:0]  cmd;
      logic [2:0]  ft;
      logic [7:0]  id;
      logic [15:0] data;
      int          pick;
      pick = $urandom_range(0, 99);
      data = 16'($urandom);
      ft   = 3'($urandom_range(0, 7));
      id   = 8'($urandom_range(0, OBJECTS - 1));
      if ($urandom_range(0, 9) == 0) id = 8'($urandom_range(128, 255));
      if (pick < 35) begin
         cmd = omrs_pkg::CMD_TICK;
      end else if (pick < 52) begin
         cmd = omrs_pkg::CMD_FRAME;
         if ($urandom_range(0, 4) != 0) begin
            if (sched.last_type == omrs_pkg::ST_READ) ft = omrs_pkg::FT_READ_ACK;
            else if (sched.last_type == omrs_pkg::ST_WRITE) ft = omrs_pkg::FT_WRITE_ACK;
         end
      end else if (pick < 67) begin
         cmd = omrs_pkg::CMD_REQ_READ;
         if ($urandom_range(0, 3) != 0) id = pick_allowed(READ_ALLOW);
      end else if (pick < 79) begin
         cmd = omrs_pkg::CMD_REQ_WRITE;
         if ($urandom_range(0, 3) != 0) id = pick_allowed(WRITE_ALLOW);
      end else if (pick < 88) begin
         cmd = omrs_pkg::CMD_STORE;
      end else if (pick < 97) begin
         cmd = omrs_pkg::CMD_FETCH;
      end else begin
         cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      drive_word(cmd, ft, id, data);
   endtask

   // random words; unless steady, with idle bursts in every other stretch of 16
   task automatic run_words(int count, bit steady);
      for (int i = 0; i < count; i++) begin
         random_word();
         if (!steady && (i / 16) % 2 == 1 && $urandom_range(0, 99) < 35)
            idle_for($urandom_range(1, 16));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers
      read_register(omrs_pkg::CSR_IDX_ENABLE);
      read_register(omrs_pkg::CSR_IDX_TIMEOUT);
      read_register(omrs_pkg::CSR_IDX_GAP);

      // master disabled: ticks do nothing, frames before any send are read responses
      drive_word(omrs_pkg::CMD_TICK, '0, '0, '0);
      drive_word(omrs_pkg::CMD_FRAME, omrs_pkg::FT_READ_ACK, 8'd3, 16'hA5A5);
      drive_word(omrs_pkg::CMD_FRAME, omrs_pkg::FT_UNKNOWN, 8'd200, 16'h0000);
      drive_word(omrs_pkg::CMD_FRAME, FT_DATA_INVALID, 8'd0, 16'h5A5A);
      drive_word(omrs_pkg::CMD_FRAME, omrs_pkg::FT_READ_ACK, 8'd255, 16'hFFFF);
      drive_word(omrs_pkg::CMD_REQ_READ, '0, 8'd0, '0);
      drive_word(omrs_pkg::CMD_REQ_READ, '0, 8'd1, '0);
      drive_word(omrs_pkg::CMD_REQ_READ, '0, 8'd128, '0);
      drive_word(omrs_pkg::CMD_REQ_WRITE, '0, 8'd1, '0);
      drive_word(omrs_pkg::CMD_REQ_WRITE, '0, 8'd0, '0);
      drive_word(omrs_pkg::CMD_REQ_WRITE, '0, 8'd255, '0);
      drive_word(omrs_pkg::CMD_STORE, '0, 8'd0, 16'hFFFF);
      drive_word(omrs_pkg::CMD_STORE, '0, 8'd200, 16'h1234);
      drive_word(omrs_pkg::CMD_FETCH, '0, 8'd0, '0);
      drive_word(omrs_pkg::CMD_FETCH, '0, 8'd3, '0);
      drive_word(omrs_pkg::CMD_FETCH, '0, 8'd127, '0);
      drive_word(omrs_pkg::CMD_FETCH, '0, 8'd255, '0);
      drive_word(CMD_SPARE_A, 3'd7, 8'hFF, 16'hFFFF);
      drive_word(CMD_SPARE_B, '0, '0, '0);

      // every tick times out: read, write, then invalid frames with the counter
      apply_settings(1'b1, 8'd1, 8'd0);
      drive_word(omrs_pkg::CMD_TICK, '0, '0, '0);
      drive_word(omrs_pkg::CMD_TICK, '0, '0, '0);
      drive_word(omrs_pkg::CMD_FRAME, omrs_pkg::FT_WRITE_ACK, 8'd1, 16'h0000);
      drive_word(omrs_pkg::CMD_FRAME, omrs_pkg::FT_UNKNOWN, 8'd1, 16'h0000);
      drive_word(omrs_pkg::CMD_TICK, '0, '0, '0);
      drive_word(omrs_pkg::CMD_FRAME, omrs_pkg::FT_READ_ACK, 8'd9, 16'hBEEF);
      drive_word(omrs_pkg::CMD_TICK, '0, '0, '0);
      run_words(PHASE_WORDS, 1'b0);

      apply_settings(1'b1, 8'd254, 8'd0);
      run_words(PHASE_WORDS, 1'b0);
      apply_settings(1'b1, 8'd3, 8'd253);
      run_words(PHASE_WORDS, 1'b0);
      apply_settings(1'b0, 8'd7, 8'd1);
      run_words(PHASE_WORDS, 1'b0);
      apply_settings(1'b1, 8'd10, 8'd2);
      run_words(PHASE_WORDS, 1'b0);
      apply_settings(1'b1, 8'($urandom_range(1, 16)), 8'($urandom_range(0, 5)));
      run_words(PHASE_WORDS, 1'b0);
      apply_settings(1'b1, 8'($urandom_range(1, 16)), 8'($urandom_range(0, 5)));
      run_words(PHASE_WORDS, 1'b1);

      settle();
      if (sched.awaited_words.size() != 0)
         sched.report_mismatch($sformatf("%0d predicted results never came",
                                         sched.awaited_words.size()));
      $display("covered %0d input words and %0d results, %0d of them sent frames",
               sched.words_noted, sched.results_checked, sched.frames_sent);
      $display("%0d register settings applied, %0d mismatches",
               settings_applied, sched.mismatches);
      if (sched.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
